// ----- design/ibs_pkg.sv -----
`timescale 1ns / 1ps
package ibs_pkg;

	localparam int CoordW  = 24;
	localparam int DiffW   = 25;
	localparam int RadW    = 25;
	localparam int SqW     = 52;
	localparam int RootW   = 26;
	localparam int ProdW   = 50;
	localparam int QuotW   = 25;
	localparam int SqrtIt  = 26;
	localparam int DivIt   = 50;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_SQRT  = 7'b0000100,
		ST_CMP   = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_APPLY = 7'b0100000,
		ST_OUT   = 7'b1000000
	} ibs_state_t;

	// axis select for the shared multiplier and divider
	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} ibs_axis_t;

	typedef struct packed {
		logic      load;      // capture point and differences
		logic      first;     // first point of a set
		logic      sq_acc;    // accumulate one square
		logic      sqrt_init;
		logic      sqrt_step;
		logic      div_init;
		logic      div_step;
		logic      apply;     // commit a moved coordinate
		logic      grow;      // commit radius
		ibs_axis_t axis;
	} ibs_cmd_t;

	typedef struct packed {
		logic grows;          // distance exceeds radius
	} ibs_sts_t;

endpackage

// ----- design/incremental_bounding_sphere.sv -----
`timescale 1ns / 1ps
// channel | signals                                         | dir
// input   | in_valid in_ready first_point point_x/y/z       | in
// output  | out_valid out_ready center_x/y/z sphere_radius  | out
// A first point goes straight to its result; a later point inside the sphere
// passes 3 squares and 26 root steps, a growing one also three divisions on
// one shared divider. One point at a time.
// Reset clears centre and radius to zero. The result register holds until
// taken; the next point is accepted once it has gone.
module incremental_bounding_sphere
	import ibs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     first_point,
	input  logic signed [CoordW-1:0] point_x,
	input  logic signed [CoordW-1:0] point_y,
	input  logic signed [CoordW-1:0] point_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [CoordW-1:0] center_x,
	output logic signed [CoordW-1:0] center_y,
	output logic signed [CoordW-1:0] center_z,
	output logic        [RadW-1:0]   sphere_radius
);

	ibs_cmd_t cmd;
	ibs_sts_t sts;

	ibs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .first_point, .in_ready,
		.out_valid, .out_ready, .sts, .cmd
	);

	ibs_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .point_x, .point_y, .point_z,
		.center_x, .center_y, .center_z, .sphere_radius
	);

endmodule

// ----- design/ibs_ctrl.sv -----
`timescale 1ns / 1ps
module ibs_ctrl
	import ibs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     first_point,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  ibs_sts_t sts,
	output ibs_cmd_t cmd
);

	ibs_state_t state_q;
	ibs_axis_t  axis_q;
	logic [5:0] cnt_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	// decode commands
	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		cmd.first = first_point;
		unique case (state_q)
			ST_IDLE:  cmd.load = in_valid && in_ready;
			ST_MUL:   cmd.sq_acc = 1'b1;
			ST_SQRT:  cmd.sqrt_step = 1'b1;
			ST_CMP:   cmd.div_init = sts.grows;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_APPLY: begin
				cmd.apply = 1'b1;
				cmd.grow = (axis_q == AX_Z);
				cmd.div_init = (axis_q != AX_Z);
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
		if (state_q == ST_MUL && axis_q == AX_Z)
			cmd.sqrt_init = 1'b1;
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= AX_X;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					axis_q <= AX_X;
					state_q <= first_point ? ST_OUT : ST_MUL;
				end
				ST_MUL: begin
					if (axis_q == AX_Z) begin
						state_q <= ST_SQRT;
						cnt_q <= '0;
						axis_q <= AX_X;
					end else axis_q <= ibs_axis_t'(axis_q + 2'd1);
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(SqrtIt - 1))
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					axis_q <= AX_X;
					cnt_q <= '0;
					state_q <= sts.grows ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DivIt - 1))
						state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					cnt_q <= '0;
					if (axis_q == AX_Z) state_q <= ST_OUT;
					else begin
						axis_q <= ibs_axis_t'(axis_q + 2'd1);
						state_q <= ST_DIV;
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("accept while busy");
	a_out_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid_q) else $error("result lost");
	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> (cnt_q < 6'(SqrtIt))) else $error("sqrt overrun");
`endif

endmodule

// ----- design/ibs_datapath.sv -----
`timescale 1ns / 1ps
module ibs_datapath
	import ibs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ibs_cmd_t                 cmd,
	output ibs_sts_t                 sts,
	input  logic signed [CoordW-1:0] point_x,
	input  logic signed [CoordW-1:0] point_y,
	input  logic signed [CoordW-1:0] point_z,
	output logic signed [CoordW-1:0] center_x,
	output logic signed [CoordW-1:0] center_y,
	output logic signed [CoordW-1:0] center_z,
	output logic        [RadW-1:0]   sphere_radius
);

	logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
	logic        [RadW-1:0]   rad_q;
	logic signed [DiffW-1:0]  ex_q, ey_q, ez_q;
	logic        [SqW-1:0]    sq_q;
	// restoring square root
	logic        [RootW-1:0]  rem_q;
	logic        [RootW-1:0]  root_q;
	// restoring division
	logic        [ProdW-1:0]  num_q;
	logic        [QuotW-1:0]  quo_q;
	logic        [RootW:0]    part_q;

	logic signed [DiffW-1:0]  e_sel;
	logic        [DiffW-2:0]  m_sel;
	logic        [RootW-1:0]  d_w;
	logic        [RootW-1:0]  s_w;
	logic        [ProdW-1:0]  prod_w;
	logic        [RootW:0]    dpart_w;
	logic        [RootW:0]    dsub_w;
	logic signed [CoordW:0]   moved_w;
	logic signed [CoordW-1:0] c_sel;
	logic        [RootW:0]    nr_w;

	// magnitude of the next axis, loaded while the current one commits
	function automatic logic [DiffW-2:0] m_next(input ibs_axis_t ax);
		logic signed [DiffW-1:0] e;
		e = (ax == AX_X) ? ey_q : ez_q;
		return e[DiffW-1] ? (DiffW-1)'(-e) : e[DiffW-2:0];
	endfunction

	assign d_w = root_q;
	assign sts.grows = (d_w > {1'b0, rad_q});
	assign s_w = (d_w - {1'b0, rad_q}) >> 1;

	// pick the axis on the shared multiplier and divider
	always_comb begin
		unique case (cmd.axis)
			AX_X:    begin e_sel = ex_q; c_sel = cx_q; end
			AX_Y:    begin e_sel = ey_q; c_sel = cy_q; end
			default: begin e_sel = ez_q; c_sel = cz_q; end
		endcase
		m_sel = e_sel[DiffW-1] ? (DiffW-1)'(-e_sel) : e_sel[DiffW-2:0];
	end

	assign prod_w  = ProdW'(m_sel) * ProdW'(m_sel);
	assign dpart_w = {part_q[RootW-1:0], num_q[ProdW-1]};
	assign dsub_w  = dpart_w - {1'b0, d_w};
	assign moved_w = e_sel[DiffW-1] ? (CoordW+1)'(c_sel) - (CoordW+1)'(quo_q)
		: (CoordW+1)'(c_sel) + (CoordW+1)'(quo_q);
	assign nr_w = ({1'b0, d_w} + (RootW+1)'(rad_q)) >> 1;

	// square-root working values: two radicand bits a step
	logic [RootW+1:0] sq_rem_w, sq_try_w;
	assign sq_rem_w = {rem_q, sq_q[SqW-1:SqW-2]};
	assign sq_try_w = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			rad_q <= '0;
		end else begin
			if (cmd.load && cmd.first) begin
				cx_q <= point_x;
				cy_q <= point_y;
				cz_q <= point_z;
				rad_q <= '0;
			end
			if (cmd.apply) begin
				unique case (cmd.axis)
					AX_X:    cx_q <= moved_w[CoordW-1:0];
					AX_Y:    cy_q <= moved_w[CoordW-1:0];
					default: cz_q <= moved_w[CoordW-1:0];
				endcase
			end
			if (cmd.grow)
				rad_q <= (nr_w > (RootW+1)'({RadW{1'b1}})) ? {RadW{1'b1}} : nr_w[RadW-1:0];
		end
	end

	// hold differences, squares, root and quotient
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ex_q <= DiffW'(point_x) - DiffW'(cx_q);
			ey_q <= DiffW'(point_y) - DiffW'(cy_q);
			ez_q <= DiffW'(point_z) - DiffW'(cz_q);
			sq_q <= '0;
		end
		if (cmd.sq_acc)
			sq_q <= sq_q + SqW'(prod_w);
		if (cmd.sqrt_init) begin
			rem_q <= '0;
			root_q <= '0;
		end
		if (cmd.sqrt_step) begin
			sq_q <= {sq_q[SqW-3:0], 2'b00};
			if (sq_rem_w >= sq_try_w) begin
				rem_q <= RootW'(sq_rem_w - sq_try_w);
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q <= sq_rem_w[RootW-1:0];
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
		if (cmd.div_init) begin
			num_q <= ProdW'(s_w) * ProdW'(cmd.apply ? m_next(cmd.axis) : m_sel);
			part_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			num_q <= {num_q[ProdW-2:0], 1'b0};
			if (!dsub_w[RootW]) begin
				part_q <= dsub_w;
				quo_q <= {quo_q[QuotW-2:0], 1'b1};
			end else begin
				part_q <= dpart_w;
				quo_q <= {quo_q[QuotW-2:0], 1'b0};
			end
		end
	end

	assign center_x = cx_q;
	assign center_y = cy_q;
	assign center_z = cz_q;
	assign sphere_radius = rad_q;

`ifndef SYNTH
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grow |-> (nr_w <= (RootW+1)'({RadW{1'b1}}))) else $error("radius overflow");
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> (quo_q <= QuotW'(m_sel))) else $error("shift beyond point");
	a_rad_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grow |=> (rad_q >= $past(rad_q))) else $error("radius shrank");
`endif

endmodule
